### rtl/core/upd_pkg.sv
// Shared types, character codes and hex helpers for the URL percent decoder.
// No dependencies; the decode core, output buffer and top level use this package.
`timescale 1ns / 1ps

package upd_pkg;

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    // Held-state codes
    localparam logic [1:0] HELD_NONE    = 2'd0;
    localparam logic [1:0] HELD_PERCENT = 2'd1;
    localparam logic [1:0] HELD_DIGIT   = 2'd2;

    // Register map, byte addresses
    localparam logic [2:0] ADDR_PLUS_AS_SPACE = 3'd0;

    typedef struct packed {
        logic [1:0]      count;      // results produced, 0..3
        logic [2:0][7:0] bytes;      // slot 0 goes out first
        logic [1:0]      next_held;
        logic            load_digit;
    } dec_result_t;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
                 (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end
        hex_value = v[3:0];
    endfunction

endpackage

### rtl/core/upd_decode.sv
// Combinational decode of one byte against the held escape state.
// Depends on upd_pkg for character codes, hex helpers and dec_result_t.
`timescale 1ns / 1ps

module upd_decode (
    input  logic [7:0]          in_byte,
    input  logic                in_final,
    input  logic [1:0]          held_count,
    input  logic [7:0]          held_digit,
    input  logic                plus_as_space,
    output upd_pkg::dec_result_t result
);

    logic [1:0]      pre_cnt;
    logic [1:0][7:0] pre_bytes;
    logic            use_fresh;
    logic            fresh_emit;
    logic [7:0]      fresh_byte;
    logic            fresh_hold;
    logic            b_hex;
    logic [1:0]      next_held;
    logic            load_digit;

    assign b_hex = upd_pkg::is_hex(in_byte);

    // Treatment of a byte when nothing is held
    always_comb begin
        fresh_emit = 1'b1;
        fresh_hold = 1'b0;
        fresh_byte = in_byte;
        if (in_byte == upd_pkg::CHAR_PERCENT) begin
            fresh_emit = in_final;
            fresh_hold = !in_final;
        end else if (in_byte == upd_pkg::CHAR_PLUS && plus_as_space) begin
            fresh_byte = upd_pkg::CHAR_SPACE;
        end
    end

    always_comb begin
        pre_cnt    = 2'd0;
        pre_bytes  = '0;
        use_fresh  = 1'b1;
        next_held  = upd_pkg::HELD_NONE;
        load_digit = 1'b0;
        case (held_count)
            upd_pkg::HELD_PERCENT: begin
                pre_cnt      = 2'd1;
                pre_bytes[0] = upd_pkg::CHAR_PERCENT;
                if (b_hex) begin
                    use_fresh = 1'b0;
                    if (in_final) begin
                        pre_cnt      = 2'd2;
                        pre_bytes[1] = in_byte;
                    end else begin
                        pre_cnt    = 2'd0;
                        next_held  = upd_pkg::HELD_DIGIT;
                        load_digit = 1'b1;
                    end
                end
            end
            upd_pkg::HELD_DIGIT: begin
                if (b_hex) begin
                    use_fresh    = 1'b0;
                    pre_cnt      = 2'd1;
                    pre_bytes[0] = {upd_pkg::hex_value(held_digit),
                                    upd_pkg::hex_value(in_byte)};
                end else begin
                    pre_cnt      = 2'd2;
                    pre_bytes[0] = upd_pkg::CHAR_PERCENT;
                    pre_bytes[1] = held_digit;
                end
            end
            default: begin
            end
        endcase
        if (use_fresh && fresh_hold) begin
            next_held = upd_pkg::HELD_PERCENT;
        end
        if (in_final) begin
            next_held = upd_pkg::HELD_NONE;
        end
    end

    always_comb begin
        result            = '0;
        result.next_held  = next_held;
        result.load_digit = load_digit;
        result.bytes[0]   = pre_bytes[0];
        result.bytes[1]   = pre_bytes[1];
        result.count      = pre_cnt;
        if (use_fresh && fresh_emit) begin
            result.count = pre_cnt + 2'd1;
            case (pre_cnt)
                2'd0:    result.bytes[0] = fresh_byte;
                2'd1:    result.bytes[1] = fresh_byte;
                default: result.bytes[2] = fresh_byte;
            endcase
        end
    end

endmodule

### rtl/core/upd_out_buf.sv
// Result register: holds the up-to-three bytes of one input and serializes them.
// Depends on upd_pkg for dec_result_t.
`timescale 1ns / 1ps

module upd_out_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  upd_pkg::dec_result_t grp_in,
    input  logic                 grp_final,
    output logic                 free,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [7:0] out_byte
    output logic                 m_tlast,   // run_last
    output logic                 m_tuser    // [0] string_end
);

    logic            grp_valid_reg;
    logic [1:0]      cnt_reg;
    logic [2:0][7:0] bytes_reg;
    logic            final_reg;
    logic [1:0]      idx_reg;
    logic            last_beat;

    assign last_beat = (idx_reg == cnt_reg - 2'd1);
    assign free      = !grp_valid_reg || (m_tready && last_beat);

    assign m_tvalid = grp_valid_reg;
    assign m_tlast  = last_beat;
    assign m_tuser  = last_beat && final_reg;

    always_comb begin
        case (idx_reg)
            2'd0:    m_tdata = bytes_reg[0];
            2'd1:    m_tdata = bytes_reg[1];
            default: m_tdata = bytes_reg[2];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end else if (load && grp_in.count != 2'd0) begin
            grp_valid_reg <= 1'b1;
            idx_reg       <= 2'd0;
        end else if (grp_valid_reg && m_tready && !last_beat) begin
            idx_reg <= idx_reg + 2'd1;
        end else if (free) begin
            grp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cnt_reg   <= grp_in.count;
            bytes_reg <= grp_in.bytes;
            final_reg <= grp_final;
        end
    end

endmodule

### rtl/core/url_percent_decoder_top.sv
// Streaming URL percent decoder: one byte in, zero to three decoded bytes out.
// An input byte is registered, decoded combinationally and registered again in the result
// register before it shows on m_*; a stall on m_tready can hold it there.
// Takes 1 byte per cycle while the result register keeps pace; an input giving N results
// holds the result register until all N are taken (N up to 3), and the next input waits.
// aresetn (synchronous, active low) empties both stages, drops any held escape
// and clears plus_as_space. Depends on upd_pkg, upd_decode, upd_out_buf.
`timescale 1ns / 1ps

module url_percent_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // in_final
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // run_last
    output logic        m_tuser,   // [0] string_end
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                 plus_reg;
    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_final_reg;
    logic [1:0]           held_count_reg;
    logic [7:0]           held_digit_reg;
    logic                 free;
    logic                 advance;
    logic                 sel_plus;
    upd_pkg::dec_result_t dec;

    // Single register; only the word offset is decoded
    assign sel_plus = (paddr[2] == upd_pkg::ADDR_PLUS_AS_SPACE[2]);
    assign pready   = 1'b1;
    assign prdata   = sel_plus ? {31'd0, plus_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plus_reg <= 1'b0;
        end else if (psel && penable && pwrite && sel_plus) begin
            plus_reg <= pwdata[0];
        end
    end

    assign advance  = in_valid_reg && free;
    assign s_tready = !in_valid_reg || free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_final_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_count_reg <= upd_pkg::HELD_NONE;
        end else if (advance) begin
            held_count_reg <= dec.next_held;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && dec.load_digit) begin
            held_digit_reg <= in_byte_reg;
        end
    end

    upd_decode u_decode (
        .in_byte       (in_byte_reg),
        .in_final      (in_final_reg),
        .held_count    (held_count_reg),
        .held_digit    (held_digit_reg),
        .plus_as_space (plus_reg),
        .result        (dec)
    );

    upd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance),
        .grp_in    (dec),
        .grp_final (in_final_reg),
        .free      (free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

### rtl/core/upd_checker.sv
// Port-level checks for the URL percent decoder, bound to the top level.
// Depends only on the ports of url_percent_decoder_top.
`timescale 1ns / 1ps

module upd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    // A stalled result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("result changed while stalled");

    // string end only on the last result of a run
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("string_end without run_last");

    // Reset empties the result side
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // With both stages drained and no new input transaction, nothing comes out
    a_no_bypass: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && !$past(m_tvalid) && $past(s_tvalid && s_tready) == 1'b0
            && $past(aresetn, 2) |=> !m_tvalid)
        else $error("result appeared without an input transaction");

endmodule

bind url_percent_decoder_top upd_checker u_upd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
